// File: design/rrs_pkg.sv
// ---------------------------------------------------------------------------
// rrs_pkg
// Shared types and codes for the round-robin ready-slot scheduler.
// ---------------------------------------------------------------------------
package rrs_pkg;

    localparam int SLOTS_DEFAULT = 16;

    localparam int TID_W = 8;   // thread identifier
    localparam int TST_W = 2;   // thread state
    localparam int RC_W  = 5;   // ready count as reported on the result beat

    // command codes
    localparam logic CMD_SET_READY  = 1'b0;
    localparam logic CMD_RESCHEDULE = 1'b1;

    // thread state codes
    localparam logic [TST_W-1:0] TSTATE_RUNNING = 2'd0;
    localparam logic [TST_W-1:0] TSTATE_READY   = 2'd1;
    localparam logic [TST_W-1:0] TSTATE_BLOCKED = 2'd2;
    localparam logic [TST_W-1:0] TSTATE_ZOMBIE  = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INSERT,
        S_POP,
        S_RESULT
    } state_t;

    // strobes from the sequencer to the slot table
    typedef struct packed {
        logic set_used;   // claim the probed slot and store the thread id
        logic clr_used;   // free the probed slot and read its thread id
    } tbl_ctl_t;

endpackage

// File: design/rrs_slot_table.sv
// ---------------------------------------------------------------------------
// rrs_slot_table
// Used bits in flip-flops and a thread-id memory, probed one slot a cycle.
// ---------------------------------------------------------------------------
module rrs_slot_table #(
    parameter int SLOTS = rrs_pkg::SLOTS_DEFAULT,
    parameter int IDX_W = $clog2(SLOTS)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  rrs_pkg::tbl_ctl_t          ctl,
    input  logic [IDX_W-1:0]           idx,
    input  logic [rrs_pkg::TID_W-1:0]  wr_thread,
    output logic                       used_at_idx,
    output logic [rrs_pkg::TID_W-1:0]  rd_thread
);
    import rrs_pkg::*;

    logic [SLOTS-1:0] used_reg;
    logic [TID_W-1:0] slot_thread_mem [SLOTS];
    logic [TID_W-1:0] rd_thread_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
        end else if (ctl.set_used) begin
            used_reg[idx] <= 1'b1;
        end else if (ctl.clr_used) begin
            used_reg[idx] <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.set_used) begin
            slot_thread_mem[idx] <= wr_thread;
        end
    end

    // read on pop; the word holds until the next pop
    always_ff @(posedge aclk) begin
        if (ctl.clr_used) begin
            rd_thread_reg <= slot_thread_mem[idx];
        end
    end

    assign used_at_idx = used_reg[idx];
    assign rd_thread   = rd_thread_reg;

endmodule

// File: design/round_robin_ready_slot_scheduler.sv
// ---------------------------------------------------------------------------
// round_robin_ready_slot_scheduler
// Ready table of SLOTS thread slots with lowest-free insertion and
// round-robin pop from a rotating scan pointer.
// ---------------------------------------------------------------------------
// One command beat in, one result beat out. A set-ready beat stores its thread
// in the lowest free slot unless the thread is already ready or the table is
// full. A reschedule beat first re-inserts the current thread (unless blocked
// or a zombie), then frees the first used slot at or after the scan pointer,
// wrapping, and returns its thread. The block takes one command at a time:
// s_tready is high only while no command is in progress. A single probe of
// the used-bit vector and the thread-id memory each cycle sets the timing.
// From the accepting edge, the insert scan, when it runs, probes up from
// slot 0 to the lowest free slot f, and the pop scan, when the table is not
// empty, probes on from the scan pointer to the first used slot, wrapping;
// the result beat is offered on the following cycle. An insert at slot f
// leaves slots 0 to f used, so the pop that follows it wraps no further
// than slot 0. No clearing pass is needed after reset: only the used bits
// are cleared, and thread ids are read only from used slots.
// ---------------------------------------------------------------------------
module round_robin_ready_slot_scheduler #(
    parameter int SLOTS = rrs_pkg::SLOTS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [7:0] thread_id, [9:8] thread_state, [15:10] zero
    input  logic [0:0]  s_tuser,    // [0] cmd

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata     // [0] accepted, [1] next_valid, [9:2] next_thread,
                                    // [14:10] ready_count, [15] zero
);
    import rrs_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(SLOTS);

    // step the probe index round the table
    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
        wrap_inc = (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] scan_ptr_reg, scan_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             cmd_reg, cmd_next;
    logic [TID_W-1:0] tid_reg, tid_next;
    logic             accepted_reg, accepted_next;
    logic             valid_reg, valid_next;

    tbl_ctl_t         tbl_ctl;
    logic             used_at_idx;
    logic [TID_W-1:0] rd_thread;

    logic             s_fire;
    logic             in_cmd;
    logic [TID_W-1:0] in_tid;
    logic [TST_W-1:0] in_state;
    logic             ins_req;
    logic             full;

    assign in_cmd   = s_tuser[0];
    assign in_tid   = s_tdata[7:0];
    assign in_state = s_tdata[9:8];
    assign s_fire   = s_tvalid && s_tready;
    assign full     = (count_reg == FULL_COUNT);

    // insertion wanted: set-ready of a thread not yet ready, or reschedule of a
    // thread that may still run
    always_comb begin
        if (in_cmd == CMD_SET_READY) begin
            ins_req = (in_state != TSTATE_READY);
        end else begin
            ins_req = (in_state != TSTATE_BLOCKED) && (in_state != TSTATE_ZOMBIE);
        end
    end

    rrs_slot_table #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_table (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (tbl_ctl),
        .idx         (idx_reg),
        .wr_thread   (tid_reg),
        .used_at_idx (used_at_idx),
        .rd_thread   (rd_thread)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    if (ins_req && !full) begin
                        state_next = S_INSERT;
                    end else if (in_cmd == CMD_RESCHEDULE && count_reg != '0) begin
                        state_next = S_POP;
                    end else begin
                        state_next = S_RESULT;
                    end
                end
            end
            S_INSERT: begin
                // a free slot always exists here, so the scan ends
                if (!used_at_idx) begin
                    state_next = (cmd_reg == CMD_RESCHEDULE) ? S_POP : S_RESULT;
                end
            end
            S_POP: begin
                if (used_at_idx) begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT: begin
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and table strobes
    always_comb begin
        idx_next      = idx_reg;
        scan_ptr_next = scan_ptr_reg;
        count_next    = count_reg;
        cmd_next      = cmd_reg;
        tid_next      = tid_reg;
        accepted_next = accepted_reg;
        valid_next    = valid_reg;
        tbl_ctl       = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    cmd_next      = in_cmd;
                    tid_next      = in_tid;
                    accepted_next = 1'b0;
                    valid_next    = 1'b0;
                    // insert scans from slot zero, pop from the scan pointer
                    idx_next      = (ins_req && !full) ? '0 : scan_ptr_reg;
                end
            end
            S_INSERT: begin
                if (!used_at_idx) begin
                    tbl_ctl.set_used = 1'b1;
                    count_next       = count_reg + 1'b1;
                    accepted_next    = 1'b1;
                    idx_next         = scan_ptr_reg;
                end else begin
                    idx_next = wrap_inc(idx_reg);
                end
            end
            S_POP: begin
                if (used_at_idx) begin
                    tbl_ctl.clr_used = 1'b1;
                    count_next       = count_reg - 1'b1;
                    valid_next       = 1'b1;
                    scan_ptr_next    = wrap_inc(idx_reg);
                end else begin
                    idx_next = wrap_inc(idx_reg);
                end
            end
            S_RESULT: begin
                // hold the result until the beat is taken
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            scan_ptr_reg <= '0;
            count_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            scan_ptr_reg <= scan_ptr_next;
            count_reg    <= count_next;
        end
    end

    // payload registers: no reset
    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        cmd_reg      <= cmd_next;
        tid_reg      <= tid_next;
        accepted_reg <= accepted_next;
        valid_reg    <= valid_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_RESULT);

    // drop the stale memory word when nothing was popped
    assign m_tdata = {1'b0,
                      RC_W'(count_reg),
                      valid_reg ? rd_thread : {TID_W{1'b0}},
                      valid_reg,
                      accepted_reg};

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_COUNT)
        else $error("ready count above table size");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_POP) |-> (count_reg != '0))
        else $error("pop scan running on an empty table");

    a_insert_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_INSERT) |-> !full)
        else $error("insert scan running on a full table");

    a_pop_decrements: assert property (@(posedge aclk) disable iff (!aresetn)
        tbl_ctl.clr_used |=> (count_reg == $past(count_reg) - 1'b1) && valid_reg)
        else $error("pop did not release one slot");

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("command accepted while a result beat is pending");
`endif

endmodule
